[rtl/scxy_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers of the serial XY stepper positioner.
// No dependencies; the files that use it refer to it by scoped names.
package scxy_pkg;

  localparam int PosBits = 16;   // stored width of positions and goals
  localparam int QDepth  = 2;    // entries in the front-to-back queue

  localparam logic [7:0] SyncByte = 8'hFF;
  localparam logic [7:0] ByteFF   = 8'hFF;

  // Frame byte counter codes: idle, data bytes 1..5 (command + 4 data), escape.
  localparam logic [2:0] FcIdle  = 3'd0;
  localparam logic [2:0] FcFirst = 3'd1;
  localparam logic [2:0] FcEsc   = 3'd6;

  localparam logic [7:0] CmdMagnetOn = 8'd1;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_X_TICK  = 2'd1,
    OP_Y_TICK  = 2'd2,
    OP_UNUSED  = 2'd3
  } scxy_op_t;

  typedef enum logic [2:0] {
    BEAT_SYNC   = 3'd0,
    BEAT_MAGNET = 3'd1,
    BEAT_X_HI   = 3'd2,
    BEAT_X_LO   = 3'd3,
    BEAT_Y_HI   = 3'd4,
    BEAT_Y_LO   = 3'd5,
    BEAT_ESC    = 3'd6
  } scxy_beat_t;

  // One queued item outcome: status after the item, and whether it ends a move.
  typedef struct packed {
    logic        magnet_on;
    logic        moving;
    logic        x_run;
    logic        y_run;
    logic        x_dir;
    logic        y_dir;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic        report;
  } scxy_desc_t;

  function automatic logic [15:0] pos_to_u16(input logic [PosBits-1:0] p);
    logic [PosBits+15:0] w;
    w = {16'd0, p};
    return w[15:0];
  endfunction

  function automatic logic [PosBits-1:0] goal_from_u16(input logic [15:0] v);
    logic [PosBits+15:0] w;
    w = {{PosBits{1'b0}}, v};
    return w[PosBits-1:0];
  endfunction

endpackage

[rtl/scxy_in_if.sv]
`timescale 1ns / 1ps
// Input channel: opcode plus received serial byte, valid/ready transfer.
// Depends on nothing.
interface scxy_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

[rtl/scxy_out_if.sv]
`timescale 1ns / 1ps
// Result channel: status fields and report byte, valid/ready transfer.
// Depends on nothing.
interface scxy_out_if;
  logic        valid;
  logic        ready;
  logic        magnet_on;
  logic        moving;
  logic        x_run;
  logic        y_run;
  logic        x_dir;
  logic        y_dir;
  logic [15:0] x_pos;
  logic [15:0] y_pos;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        last;

  modport source (output valid, output magnet_on, output moving, output x_run, output y_run,
                  output x_dir, output y_dir, output x_pos, output y_pos, output tx_valid,
                  output tx_byte, output last, input ready);
  modport sink   (input valid, input magnet_on, input moving, input x_run, input y_run,
                  input x_dir, input y_dir, input x_pos, input y_pos, input tx_valid,
                  input tx_byte, input last, output ready);
endinterface

[rtl/serial_command_xy_stepper_positioner_unit.sv]
`timescale 1ns / 1ps
// Serial-commanded XY stepper positioner. Each input transfer is a received serial
// byte or a step tick for one axis, and the front part handles it as it is accepted:
// it assembles 7-byte frames (sync 255, command, four data bytes, escape), executes
// commands 0/1 (magnet off/on, new X/Y targets) and steps a running axis on its tick.
// Outcomes pass through a two-entry queue to the back part, which emits one status
// result per item, or seven report transfers (sync, magnet, X hi/lo, Y hi/lo, escape)
// for an item that completes a move. Input is accepted every cycle while the queue has
// room; the result port sets the pace, since an item leaves on its last transfer.
// Depends on scxy_pkg, scxy_in_if, scxy_out_if, scxy_front, scxy_queue, scxy_back.
module serial_command_xy_stepper_positioner_unit (
  input  logic       clk,
  input  logic       rst,
  scxy_in_if.sink    item,
  scxy_out_if.source result
);

  logic                 q_ready;
  logic                 push;
  logic                 pop;
  logic                 head_valid;
  scxy_pkg::scxy_desc_t pdesc;
  scxy_pkg::scxy_desc_t head_data;

  // Front: parse, execute, step; hold off input when the queue is full.
  scxy_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_ready (q_ready),
    .push    (push),
    .pdesc   (pdesc)
  );

  // Queue: decouple execution from result delivery.
  scxy_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (pdesc),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Back: serialise each outcome as a status result or an escaped report.
  scxy_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .result     (result)
  );

endmodule

[rtl/scxy_front.sv]
`timescale 1ns / 1ps
// Front part: frame parser, command execution and axis stepping, one item a cycle
// while the queue has room. Depends on scxy_pkg and scxy_in_if.
module scxy_front (
  input  logic                 clk,
  input  logic                 rst,
  scxy_in_if.sink              item,
  input  logic                 q_ready,
  output logic                 push,
  output scxy_pkg::scxy_desc_t pdesc
);

  logic [2:0] frame_count, frame_count_next;
  logic [7:0] frame_bytes [5];
  logic       fb_we;
  logic       magnet_state, magnet_state_next;
  logic       move_active, move_active_next;
  logic       x_running, x_running_next, y_running, y_running_next;
  logic       x_direction, x_direction_next, y_direction, y_direction_next;
  logic [scxy_pkg::PosBits-1:0] x_position, x_position_next, y_position, y_position_next;
  logic [scxy_pkg::PosBits-1:0] x_goal, x_goal_next, y_goal, y_goal_next;
  logic       x_at_goal, x_at_goal_next, y_at_goal, y_at_goal_next;
  logic       report;
  logic [7:0] d0, d1, d2, d3;
  logic [scxy_pkg::PosBits-1:0] x_cand, y_cand;

  assign item.ready = q_ready;
  assign push       = item.valid & q_ready;

  // Data bytes with escape applied; escape bits 3..0 force bytes 1..4 to all ones.
  assign d0 = item.rx_byte[3] ? scxy_pkg::ByteFF : frame_bytes[1];
  assign d1 = item.rx_byte[2] ? scxy_pkg::ByteFF : frame_bytes[2];
  assign d2 = item.rx_byte[1] ? scxy_pkg::ByteFF : frame_bytes[3];
  assign d3 = item.rx_byte[0] ? scxy_pkg::ByteFF : frame_bytes[4];
  assign x_cand = scxy_pkg::goal_from_u16({d0, d1});
  assign y_cand = scxy_pkg::goal_from_u16({d2, d3});

  always_comb begin
    frame_count_next = frame_count;
    fb_we            = 1'b0;
    magnet_state_next = magnet_state;
    move_active_next = move_active;
    x_running_next   = x_running;
    y_running_next   = y_running;
    x_direction_next = x_direction;
    y_direction_next = y_direction;
    x_position_next  = x_position;
    y_position_next  = y_position;
    x_goal_next      = x_goal;
    y_goal_next      = y_goal;
    x_at_goal_next   = x_at_goal;
    y_at_goal_next   = y_at_goal;
    report           = 1'b0;
    if (push) begin
      unique case (scxy_pkg::scxy_op_t'(item.opcode))
        scxy_pkg::OP_RX_BYTE: begin
          if (frame_count == scxy_pkg::FcIdle) begin
            if (item.rx_byte == scxy_pkg::SyncByte) frame_count_next = scxy_pkg::FcFirst;
          end else if (frame_count < scxy_pkg::FcEsc) begin
            fb_we            = 1'b1;
            frame_count_next = frame_count + 3'd1;
          end else begin
            frame_count_next = scxy_pkg::FcIdle;
            if (frame_bytes[0] <= scxy_pkg::CmdMagnetOn) begin
              magnet_state_next = frame_bytes[0][0];
              x_goal_next       = x_cand;
              y_goal_next       = y_cand;
              move_active_next  = 1'b1;
              x_at_goal_next    = (x_cand == x_position);
              y_at_goal_next    = (y_cand == y_position);
              if (x_cand != x_position) x_running_next = 1'b1;
              if (y_cand != y_position) y_running_next = 1'b1;
            end
          end
        end
        scxy_pkg::OP_X_TICK: begin
          if (x_running && move_active) begin
            x_at_goal_next = (x_goal == x_position);
            if (x_goal == x_position) begin
              x_running_next = 1'b0;
            end else if (x_goal > x_position) begin
              x_position_next  = x_position + 1'b1;
              x_direction_next = 1'b1;
            end else begin
              x_position_next  = x_position - 1'b1;
              x_direction_next = 1'b0;
            end
          end
        end
        scxy_pkg::OP_Y_TICK: begin
          if (y_running && move_active) begin
            y_at_goal_next = (y_goal == y_position);
            if (y_goal == y_position) begin
              y_running_next = 1'b0;
            end else if (y_goal > y_position) begin
              y_position_next  = y_position + 1'b1;
              y_direction_next = 1'b1;
            end else begin
              y_position_next  = y_position - 1'b1;
              y_direction_next = 1'b0;
            end
          end
        end
        default: ;
      endcase
      // End of move: stop both axes and ask the back part for a report.
      if (move_active_next && x_at_goal_next && y_at_goal_next) begin
        report           = 1'b1;
        move_active_next = 1'b0;
        x_running_next   = 1'b0;
        y_running_next   = 1'b0;
      end
    end
  end

  always_comb begin
    pdesc.magnet_on = magnet_state_next;
    pdesc.moving    = move_active_next;
    pdesc.x_run     = x_running_next;
    pdesc.y_run     = y_running_next;
    pdesc.x_dir     = x_direction_next;
    pdesc.y_dir     = y_direction_next;
    pdesc.x_pos     = scxy_pkg::pos_to_u16(x_position_next);
    pdesc.y_pos     = scxy_pkg::pos_to_u16(y_position_next);
    pdesc.report    = report;
  end

  always_ff @(posedge clk) begin
    if (fb_we) frame_bytes[frame_count - 3'd1] <= item.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= scxy_pkg::FcIdle;
      magnet_state <= 1'b0;
      move_active  <= 1'b0;
      x_running    <= 1'b0;
      y_running    <= 1'b0;
      x_direction  <= 1'b0;
      y_direction  <= 1'b0;
      x_position   <= '0;
      y_position   <= '0;
      x_goal       <= '0;
      y_goal       <= '0;
      x_at_goal    <= 1'b1;
      y_at_goal    <= 1'b1;
    end else begin
      frame_count  <= frame_count_next;
      magnet_state <= magnet_state_next;
      move_active  <= move_active_next;
      x_running    <= x_running_next;
      y_running    <= y_running_next;
      x_direction  <= x_direction_next;
      y_direction  <= y_direction_next;
      x_position   <= x_position_next;
      y_position   <= y_position_next;
      x_goal       <= x_goal_next;
      y_goal       <= y_goal_next;
      x_at_goal    <= x_at_goal_next;
      y_at_goal    <= y_at_goal_next;
    end
  end

  a_report_ends_move: assert property (@(posedge clk) disable iff (rst)
    (push && pdesc.report) |=> (!move_active && !x_running && !y_running))
    else $error("report issued but move state not cleared");

endmodule

[rtl/scxy_queue.sv]
`timescale 1ns / 1ps
// Short queue between front and back parts, holding item outcomes.
// Depends on scxy_pkg.
module scxy_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  scxy_pkg::scxy_desc_t push_data,
  output logic                 q_ready,
  input  logic                 pop,
  output logic                 head_valid,
  output scxy_pkg::scxy_desc_t head_data
);

  localparam int PtrBits = (scxy_pkg::QDepth > 1) ? $clog2(scxy_pkg::QDepth) : 1;
  localparam int CntBits = $clog2(scxy_pkg::QDepth + 1);

  scxy_pkg::scxy_desc_t entries [scxy_pkg::QDepth];
  logic [PtrBits-1:0] wr_ptr, rd_ptr;
  logic [CntBits-1:0] count;

  assign q_ready    = (count != CntBits'(scxy_pkg::QDepth));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrBits'(scxy_pkg::QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrBits'(scxy_pkg::QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty queue");

endmodule

[rtl/scxy_back.sv]
`timescale 1ns / 1ps
// Back part: turns each queued outcome into a status result or a 7-byte report.
// Depends on scxy_pkg and scxy_out_if.
module scxy_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  scxy_pkg::scxy_desc_t head_data,
  output logic                 pop,
  scxy_out_if.source           result
);

  scxy_pkg::scxy_beat_t beat;
  logic       last_beat;
  logic [7:0] xh, xl, yh, yl;
  logic [7:0] esc;
  logic [7:0] rbyte;

  assign xh = head_data.x_pos[15:8];
  assign xl = head_data.x_pos[7:0];
  assign yh = head_data.y_pos[15:8];
  assign yl = head_data.y_pos[7:0];
  assign esc = {4'd0, xh == scxy_pkg::ByteFF, xl == scxy_pkg::ByteFF,
                yh == scxy_pkg::ByteFF, yl == scxy_pkg::ByteFF};

  always_comb begin
    unique case (beat)
      scxy_pkg::BEAT_SYNC:   rbyte = scxy_pkg::SyncByte;
      scxy_pkg::BEAT_MAGNET: rbyte = {7'd0, head_data.magnet_on};
      scxy_pkg::BEAT_X_HI:   rbyte = esc[3] ? 8'd0 : xh;
      scxy_pkg::BEAT_X_LO:   rbyte = esc[2] ? 8'd0 : xl;
      scxy_pkg::BEAT_Y_HI:   rbyte = esc[1] ? 8'd0 : yh;
      scxy_pkg::BEAT_Y_LO:   rbyte = esc[0] ? 8'd0 : yl;
      scxy_pkg::BEAT_ESC:    rbyte = esc;
      default:               rbyte = 8'd0;
    endcase
  end

  assign last_beat = !head_data.report || (beat == scxy_pkg::BEAT_ESC);
  assign pop       = head_valid && result.ready && last_beat;

  assign result.valid     = head_valid;
  assign result.magnet_on = head_data.magnet_on;
  assign result.moving    = head_data.moving;
  assign result.x_run     = head_data.x_run;
  assign result.y_run     = head_data.y_run;
  assign result.x_dir     = head_data.x_dir;
  assign result.y_dir     = head_data.y_dir;
  assign result.x_pos     = head_data.x_pos;
  assign result.y_pos     = head_data.y_pos;
  assign result.tx_valid  = head_data.report;
  assign result.tx_byte   = head_data.report ? rbyte : 8'd0;
  assign result.last      = last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= scxy_pkg::BEAT_SYNC;
    end else if (head_valid && result.ready) begin
      beat <= last_beat ? scxy_pkg::BEAT_SYNC : scxy_pkg::scxy_beat_t'(3'(beat) + 3'd1);
    end
  end

  a_beat_step: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && !result.last) |=> (3'(beat) == 3'($past(beat)) + 3'd1))
    else $error("report beat did not advance");

  a_beat_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (beat == $past(beat)))
    else $error("report beat moved while stalled");

endmodule
